[hw/rtl/bbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bbf_pkg;

   localparam logic [31:0] HASH_SEED  = 32'd2568;
   localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2     = 32'h1b873593;
   localparam logic [31:0] MIX_ADD    = 32'he6546b64;
   localparam logic [31:0] FIN_C1     = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2     = 32'hc2b2ae35;
   localparam logic [31:0] KEY_LENGTH = 32'd8;
   localparam int          PROBE_SHIFT = 16;
   localparam logic [2:0]  BIT_IN_BYTE_MASK = 3'h7;
   localparam int          NUM_HASHES_W = 5;
   localparam int          BLOCKS_W = 13;
   localparam int          CSR_INDEX_W = 2;
   localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RESET = 5'd7;
   localparam logic [BLOCKS_W-1:0]     BLOCKS_RESET = 13'd4096;
   localparam logic [CSR_INDEX_W-1:0]  REG_NUM_HASHES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0]  REG_BLOCKS_IN_USE = 2'd1;

   typedef enum logic [3:0] {
      HS_LO_MUL1,
      HS_LO_MUL2,
      HS_LO_MIX,
      HS_HI_MUL1,
      HS_HI_MUL2,
      HS_HI_MIX,
      HS_FIN1,
      HS_FIN2,
      HS_FIN3
   } hash_step_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD_BLOCK,
      ST_READ_WAIT,
      ST_PROBE_START,
      ST_PROBE_WAIT,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic          load_item;
      logic          hash_en;
      hash_step_type hash_step;
      logic          mod_start;
      logic          mod_probe;
      logic          ram_rd;
      logic          blk_load;
      logic          probe_test;
      logic          ram_wr;
      logic          clr_wr;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic probe_last;
      logic k_zero;
      logic is_lookup;
      logic clr_last;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/bbf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module bbf_ram #(
   parameter int WIDTH = 512,
   parameter int DEPTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[hw/rtl/bbf_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
module bbf_mod #(
   parameter int DW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [31:0]   dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      remainder
);
   logic [31:0]   dvd_ff, dvd_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [DW:0]   trial;

   always_comb begin
      dvd_in = dvd_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, dvd_ff[31]};
      if (start) begin
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = (cnt_ff == 6'd0);
   assign remainder = rem_ff;
endmodule
`default_nettype wire

[hw/rtl/bbf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bbf_datapath
   import bbf_pkg::*;
#(
   parameter int BLOCK_BYTES = 64,
   parameter int NUM_BLOCKS  = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BLOCKS_W-1:0]    csr_data,
   input  wire logic                   req_action,
   input  wire logic [63:0]            req_key,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_present
);
   localparam int BITS = BLOCK_BYTES * 8;
   localparam int AW = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
   localparam int PW = $clog2(BITS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int BWC = $clog2(BITS + 1);
   localparam int MDW0 = CW > BWC ? CW : BWC;
   localparam int MDW = MDW0 > BLOCKS_W ? MDW0 : BLOCKS_W;
   localparam logic [MDW-1:0] NB_M = MDW'(NUM_BLOCKS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);
   localparam logic [31:0] BITS_32 = 32'(BITS);
   localparam logic [31:0] PROBE_RECIP = 32'((64'd1 << 32) / 64'(BITS));

   logic [NUM_HASHES_W-1:0] k_ff, k_in;
   logic [BLOCKS_W-1:0]     nb_ff, nb_in;
   logic [63:0]             key_ff;
   logic                    act_ff;
   logic [31:0]             h_ff, h_in, w_ff, w_in;
   logic [NUM_HASHES_W-1:0] i_ff, i_in;
   logic                    all_ff, all_in;
   logic [AW-1:0]           blk_ff;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [BITS-1:0]         data_ff, data_in;
   logic                    rv_ff, rv_in, rp_ff, rp_in;
   logic [BITS-1:0]         rd_data;
   logic [31:0]             probe, mix, fin;
   logic [63:0]             prod;
   logic [63:0]             qprod;
   logic [31:0]             pq_ff, pq_in;
   logic [31:0]             prem_raw;
   logic [PW-1:0]           prem;
   logic [MDW-1:0]          count, rem;
   logic                    mod_done;
   logic [PW-1:0]           bit_idx;
   logic [AW-1:0]           wr_addr;

   function automatic logic [63:0] req_key_lo_mul(input logic [31:0] x);
      return {32'd0, x} * {32'd0, MIX_C1};
   endfunction

   always_comb begin
      k_in  = k_ff;
      nb_in = nb_ff;
      if (csr_valid && csr_index == REG_NUM_HASHES) begin
         k_in = csr_data[NUM_HASHES_W-1:0];
      end
      if (csr_valid && csr_index == REG_BLOCKS_IN_USE) begin
         nb_in = csr_data;
      end
   end

   always_comb begin
      if (nb_ff == '0) begin
         count = MDW'(1);
      end else if (MDW'(nb_ff) > NB_M) begin
         count = NB_M;
      end else begin
         count = MDW'(nb_ff);
      end
   end

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      prod = '0;
      mix  = '0;
      fin  = '0;
      if (cmd.load_item) begin
         h_in = HASH_SEED;
      end else if (cmd.hash_en) begin
         unique case (cmd.hash_step)
            HS_LO_MUL1: begin
               prod = req_key_lo_mul(key_ff[31:0]);
               w_in = prod[31:0];
            end
            HS_HI_MUL1: begin
               prod = req_key_lo_mul(key_ff[63:32]);
               w_in = prod[31:0];
            end
            HS_LO_MUL2, HS_HI_MUL2: begin
               prod = {32'd0, {w_ff[16:0], w_ff[31:17]}} * {32'd0, MIX_C2};
               w_in = prod[31:0];
            end
            HS_LO_MIX, HS_HI_MIX: begin
               mix  = h_ff ^ w_ff;
               mix  = {mix[18:0], mix[31:19]};
               h_in = {mix[29:0], 2'b00} + mix + MIX_ADD;
            end
            HS_FIN1: begin
               fin  = h_ff ^ KEY_LENGTH;
               fin  = fin ^ (fin >> 16);
               prod = {32'd0, fin} * {32'd0, FIN_C1};
               h_in = prod[31:0];
            end
            HS_FIN2: begin
               fin  = h_ff ^ (h_ff >> 13);
               prod = {32'd0, fin} * {32'd0, FIN_C2};
               h_in = prod[31:0];
            end
            HS_FIN3: begin
               h_in = h_ff ^ (h_ff >> 16);
            end
            default: begin
               h_in = h_ff;
            end
         endcase
      end
   end

   assign probe = (h_ff >> PROBE_SHIFT) ^ (h_ff << i_ff);

   bbf_mod #(.DW(MDW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (h_in),
      .divisor   (count),
      .done      (mod_done),
      .remainder (rem)
   );

   // Probe position: estimated quotient by reciprocal, then one correction step
   always_comb begin
      pq_in = pq_ff;
      qprod = '0;
      if (cmd.mod_probe) begin
         qprod = {32'd0, probe} * {32'd0, PROBE_RECIP};
         pq_in = qprod[63:32];
      end
   end

   assign prem_raw = probe - pq_ff * BITS_32;
   assign prem     = (prem_raw >= BITS_32) ? PW'(prem_raw - BITS_32) : prem_raw[PW-1:0];
   assign bit_idx  = prem ^ PW'(BIT_IN_BYTE_MASK);

   always_comb begin
      i_in    = i_ff;
      all_in  = all_ff;
      data_in = data_ff;
      if (cmd.load_item) begin
         i_in   = '0;
         all_in = 1'b1;
      end
      if (cmd.blk_load) begin
         data_in = rd_data;
      end
      if (cmd.probe_test) begin
         i_in = i_ff + NUM_HASHES_W'(1);
         if (!data_ff[bit_idx]) begin
            all_in = 1'b0;
         end
         data_in[bit_idx] = 1'b1;
      end
   end

   assign clr_in = cmd.clr_wr ? clr_ff + AW'(1) : clr_ff;

   always_comb begin
      rv_in = rv_ff;
      rp_in = rp_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rv_in = 1'b1;
         rp_in = all_ff;
      end
   end

   assign wr_addr = cmd.clr_wr ? clr_ff : blk_ff;

   bbf_ram #(.WIDTH(BITS), .DEPTH(NUM_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_wr | cmd.ram_wr),
      .wr_addr (wr_addr),
      .wr_data (cmd.clr_wr ? '0 : data_ff),
      .rd_en   (cmd.ram_rd),
      .rd_addr (rem[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= NUM_HASHES_RESET;
         nb_ff  <= BLOCKS_RESET;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
         i_ff   <= '0;
      end else begin
         k_ff   <= k_in;
         nb_ff  <= nb_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
         i_ff   <= i_in;
      end
      if (cmd.load_item) begin
         key_ff <= req_key;
         act_ff <= req_action;
      end
      if (cmd.ram_rd) begin
         blk_ff <= rem[AW-1:0];
      end
      h_ff    <= h_in;
      w_ff    <= w_in;
      pq_ff   <= pq_in;
      all_ff  <= all_in;
      data_ff <= data_in;
      rp_ff   <= rp_in;
   end

   assign status.mod_done   = mod_done;
   assign status.probe_last = (i_ff == k_ff - NUM_HASHES_W'(1));
   assign status.k_zero     = (k_ff == '0);
   assign status.is_lookup  = act_ff;
   assign status.clr_last   = (clr_ff == LAST_ADDR);
   assign status.rsp_busy   = rv_ff & ~rsp_ready;

   assign rsp_valid   = rv_ff;
   assign rsp_present = rp_ff;
endmodule
`default_nettype wire

[hw/rtl/bbf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bbf_ctrl
   import bbf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type     state_ff, state_in;
   hash_step_type hs_ff, hs_in;

   always_comb begin
      state_in = state_ff;
      hs_in    = hs_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HASH;
               hs_in    = HS_LO_MUL1;
            end
         end
         ST_HASH: begin
            if (hs_ff == HS_FIN3) begin
               state_in = ST_MOD_BLOCK;
            end else begin
               hs_in = hash_step_type'(hs_ff + 4'd1);
            end
         end
         ST_MOD_BLOCK: begin
            if (status.mod_done) begin
               state_in = ST_READ_WAIT;
            end
         end
         ST_READ_WAIT: begin
            state_in = status.k_zero ? ST_RESP : ST_PROBE_START;
         end
         ST_PROBE_START: begin
            state_in = ST_PROBE_WAIT;
         end
         ST_PROBE_WAIT: begin
            state_in = status.probe_last ? ST_WRITE : ST_PROBE_START;
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.hash_step = hs_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_HASH: begin
            cmd.hash_en   = 1'b1;
            cmd.mod_start = (hs_ff == HS_FIN3);
         end
         ST_MOD_BLOCK: begin
            cmd.ram_rd = status.mod_done;
         end
         ST_READ_WAIT: begin
            cmd.blk_load = 1'b1;
         end
         ST_PROBE_START: begin
            cmd.mod_probe = 1'b1;
         end
         ST_PROBE_WAIT: begin
            cmd.probe_test = 1'b1;
         end
         ST_WRITE: begin
            cmd.ram_wr = ~status.is_lookup;
         end
         ST_RESP: begin
            cmd.rsp_load = ~status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         hs_ff    <= HS_LO_MUL1;
      end else begin
         state_ff <= state_in;
         hs_ff    <= hs_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/blocked_bloom_filter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_action, req_key
// rsp      out        rsp_valid/rsp_ready    rsp_present
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item at a time: an accept, 9 hash steps, the serial block modulo (its
// last step issues the read), a read wait, a probe start and a probe wait per
// hash, a write-back and a response; zero hashes skip probes and write-back.
// After reset a clearing pass writes zeros to all NUM_BLOCKS blocks, one per
// cycle; req_ready stays low during it. csr writes are always taken.
// A stalled rsp holds its item; the next item waits only at its own response.
module blocked_bloom_filter_core
   import bbf_pkg::*;
#(
   parameter int BLOCK_BYTES = 64,
   parameter int NUM_BLOCKS  = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [63:0]            req_key,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_present,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BLOCKS_W-1:0]    csr_data
);
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbf_datapath #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .NUM_BLOCKS  (NUM_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_action  (req_action),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_present (rsp_present)
   );
endmodule
`default_nettype wire
